FILE: hw/rtl/pbau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbau_pkg
// Shared types and constants of the pixel blend arithmetic unit.
// ----------------------------------------------------------------------------
package pbau_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int FACTOR_BITS  = 12;
  localparam int FRAC_BITS    = 8;
  localparam int UNIT_BITS    = FRAC_BITS + 1;
  localparam int SUM_BITS     = CHANNEL_BITS + FACTOR_BITS + 3;
  localparam int ADDR_BITS    = 3;
  localparam int DATA_BITS    = 32;

  localparam logic [CHANNEL_BITS-1:0] MAXV = {CHANNEL_BITS{1'b1}};
  localparam logic [UNIT_BITS-1:0]    Q_ONE = UNIT_BITS'(1 << FRAC_BITS);

  typedef enum logic [3:0] {
    OP_BLEND   = 4'd0,
    OP_ABSDIFF = 4'd1,
    OP_MAX     = 4'd2,
    OP_MIN     = 4'd3,
    OP_OR      = 4'd4,
    OP_AND     = 4'd5,
    OP_XOR     = 4'd6,
    OP_NEGATE  = 4'd7,
    OP_DARKEN  = 4'd8,
    OP_LIGHTEN = 4'd9
  } op_t;

  typedef enum logic [0:0] {
    REG_OPERATION    = 1'd0,
    REG_BLEND_FACTOR = 1'd1
  } reg_index_t;

  typedef struct packed {
    logic [3:0]                    operation;
    logic signed [FACTOR_BITS-1:0] blend_factor;
  } cfg_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] pixel;
    logic                    clipped;
  } result_t;

endpackage

FILE: hw/rtl/pbau_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbau_cfg_regs
// APB-style register file holding the operation code and the blend factor.
// ----------------------------------------------------------------------------
module pbau_cfg_regs
  import pbau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  cfg_t       regs;
  logic       wr_en;
  reg_index_t index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign index  = reg_index_t'(paddr[2]);
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.operation    <= OP_BLEND;
      regs.blend_factor <= '0;
    end else if (wr_en) begin
      unique case (index)
        REG_OPERATION:    regs.operation    <= pwdata[3:0];
        REG_BLEND_FACTOR: regs.blend_factor <= $signed(pwdata[FACTOR_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_OPERATION:    prdata = DATA_BITS'(regs.operation);
      REG_BLEND_FACTOR: prdata = DATA_BITS'(unsigned'(regs.blend_factor));
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/pbau_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbau_alu
// Single-pass datapath computing one result channel from a pixel pair.
// ----------------------------------------------------------------------------
module pbau_alu
  import pbau_pkg::*;
(
  input  logic [CHANNEL_BITS-1:0] a,
  input  logic [CHANNEL_BITS-1:0] b,
  input  cfg_t                    cfg,
  output result_t                 result
);

  localparam logic signed [SUM_BITS-1:0] ONE_S     = SUM_BITS'(1 << FRAC_BITS);
  localparam logic signed [SUM_BITS-1:0] LOW_LIMIT = -SUM_BITS'((1 << FRAC_BITS) - 1);

  logic signed [FACTOR_BITS-1:0]  f;
  logic                           f_neg;
  logic                           f_over;
  logic [CHANNEL_BITS-1:0]        op_a;
  logic [CHANNEL_BITS-1:0]        op_b;
  logic signed [SUM_BITS-1:0]     ea;
  logic signed [SUM_BITS-1:0]     eb;
  logic signed [SUM_BITS-1:0]     ef;
  logic signed [SUM_BITS-1:0]     eg;
  logic signed [SUM_BITS-1:0]     sum;
  logic [CHANNEL_BITS-1:0]        blend_pixel;
  logic                           blend_clip;
  logic [UNIT_BITS-1:0]           fu;
  logic [CHANNEL_BITS+UNIT_BITS-1:0] dark_prod;
  logic [CHANNEL_BITS+UNIT_BITS-1:0] light_prod;

  assign f      = cfg.blend_factor;
  assign f_neg  = f[FACTOR_BITS-1];
  assign f_over = !f_neg && (f > $signed(FACTOR_BITS'(Q_ONE)));

  always_comb begin
    op_a = f_over ? MAXV - a : a;
    op_b = f_neg ? MAXV - b : b;
    ea   = $signed({{(SUM_BITS-CHANNEL_BITS){1'b0}}, op_a});
    eb   = $signed({{(SUM_BITS-CHANNEL_BITS){1'b0}}, op_b});
    ef   = {{(SUM_BITS-FACTOR_BITS){f[FACTOR_BITS-1]}}, f};
    eg   = ONE_S - ef;
    sum  = ea * eg + eb * ef;

    blend_clip  = 1'b0;
    blend_pixel = sum[CHANNEL_BITS+FRAC_BITS-1:FRAC_BITS];
    if (f == '0) begin
      blend_pixel = a;
    end else if (f == $signed(FACTOR_BITS'(Q_ONE))) begin
      blend_pixel = b;
    end else if (sum < LOW_LIMIT) begin
      blend_pixel = '0;
      blend_clip  = 1'b1;
    end else if (sum[SUM_BITS-1]) begin
      blend_pixel = '0;
    end else if (sum[SUM_BITS-1:CHANNEL_BITS+FRAC_BITS] != '0) begin
      blend_pixel = MAXV;
      blend_clip  = 1'b1;
    end
  end

  always_comb begin
    if (f_neg) begin
      fu = '0;
    end else if (f_over) begin
      fu = Q_ONE;
    end else begin
      fu = f[UNIT_BITS-1:0];
    end
    dark_prod  = (CHANNEL_BITS+UNIT_BITS)'(a) * (CHANNEL_BITS+UNIT_BITS)'(Q_ONE - fu);
    light_prod = (CHANNEL_BITS+UNIT_BITS)'(MAXV - a) * (CHANNEL_BITS+UNIT_BITS)'(fu);
  end

  always_comb begin
    result.clipped = 1'b0;
    case (cfg.operation)
      OP_BLEND: begin
        result.pixel   = blend_pixel;
        result.clipped = blend_clip;
      end
      OP_ABSDIFF: result.pixel = (a > b) ? a - b : b - a;
      OP_MAX:     result.pixel = (a > b) ? a : b;
      OP_MIN:     result.pixel = (a < b) ? a : b;
      OP_OR:      result.pixel = a | b;
      OP_AND:     result.pixel = a & b;
      OP_XOR:     result.pixel = a ^ b;
      OP_NEGATE:  result.pixel = ~a;
      OP_DARKEN:  result.pixel = dark_prod[CHANNEL_BITS+FRAC_BITS-1:FRAC_BITS];
      OP_LIGHTEN: result.pixel = a + light_prod[CHANNEL_BITS+FRAC_BITS-1:FRAC_BITS];
      default:    result.pixel = a;
    endcase
  end

endmodule

FILE: hw/rtl/pixel_blend_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_blend_arithmetic_unit_core
// Combines a channel of image A with a channel of image B per the configured
// operation: blend, difference, max, min, logic ops, negate, darken, lighten.
//
// Usage:
// The input channel carries pixel_a and pixel_b under in_valid/in_ready; the
// output channel carries pixel_out and clipped under out_valid/out_ready.
// Operation and blend factor are set through the APB-style port, register 0
// at byte address 0 and register 1 at byte address 4, while the unit is idle.
// Each accepted beat is captured in an input register, passes through one
// combinational arithmetic stage and lands in the result register, where
// it is offered on the output channel. One beat can be accepted every
// cycle while out_ready is high; throughput is then one result per clock,
// set by the single-pass datapath between the two registers.
// When out_ready is low, the result register holds its beat and the input
// register keeps one more; in_ready then drops until the output drains.
// Synchronous reset empties both registers and returns operation and blend
// factor to zero.
// ----------------------------------------------------------------------------
module pixel_blend_arithmetic_unit_core
  import pbau_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_BITS-1:0]    paddr,
  input  logic [DATA_BITS-1:0]    pwdata,
  output logic [DATA_BITS-1:0]    prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] pixel_a,
  input  logic [CHANNEL_BITS-1:0] pixel_b,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHANNEL_BITS-1:0] pixel_out,
  output logic                    clipped
);

  cfg_t                    cfg;
  result_t                 alu_result;
  logic                    stage_valid;
  logic [CHANNEL_BITS-1:0] stage_a;
  logic [CHANNEL_BITS-1:0] stage_b;
  logic                    res_valid;
  result_t                 res;
  logic                    res_load;

  pbau_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbau_alu u_alu (
    .a      (stage_a),
    .b      (stage_b),
    .cfg    (cfg),
    .result (alu_result)
  );

  assign res_load = !res_valid || out_ready;
  assign in_ready = !stage_valid || res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (res_load) begin
        res_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_a <= pixel_a;
      stage_b <= pixel_b;
    end
    if (res_load && stage_valid) begin
      res <= alu_result;
    end
  end

  assign out_valid = res_valid;
  assign pixel_out = res.pixel;
  assign clipped   = res.clipped;

endmodule
